@@ hw/rtl/cartridge_rom_checksum_unit_assert.svh @@
// Assertion macros for the checksum unit's checker.
`ifndef CARTRIDGE_ROM_CHECKSUM_UNIT_ASSERT_SVH
`define CARTRIDGE_ROM_CHECKSUM_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CROM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("checksum unit assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define CROM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("checksum unit assertion failed");

// Next-cycle implication that is also checked across reset.
`define CROM_ASSERT_NXT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("checksum unit reset assertion failed");

`endif

@@ hw/rtl/crom_pkg.sv @@
// Types, constants and helper functions of the cartridge ROM checksum unit.
package crom_pkg;

    localparam int TABLE_WORDS = 64;
    localparam int TBL_AW      = $clog2(TABLE_WORDS);
    localparam int PATCH_INDEX = 0;
    localparam logic [TBL_AW-1:0] PATCH_ADDR = TBL_AW'(PATCH_INDEX);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH   = CFG_IDX_W'(1);

    localparam logic [1:0] VAR_6102 = 2'd0;
    localparam logic [1:0] VAR_6103 = 2'd1;
    localparam logic [1:0] VAR_6105 = 2'd2;
    localparam logic [1:0] VAR_6106 = 2'd3;

    localparam logic ACT_TABLE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TBL_AW-1:0] table_index;
        logic [31:0]       word;
        logic              last;
    } t_in_req;

    typedef struct packed {
        logic [31:0] checksum_one;
        logic [31:0] checksum_two;
    } t_out_res;

    // The six running accumulators as they stand after a word.
    typedef struct packed {
        logic [31:0] mix_sum;
        logic [31:0] select_xor;
        logic [31:0] plain_xor;
        logic [31:0] carry_count;
        logic [31:0] rotate_sum;
        logic [31:0] plain_sum;
    } t_acc;

    function automatic logic [31:0] variant_seed(input logic [1:0] variant);
        logic [31:0] seed;
        case (variant)
            VAR_6102: seed = 32'hF8CA4DDC;
            VAR_6103: seed = 32'hA3886759;
            VAR_6105: seed = 32'hDF26F436;
            VAR_6106: seed = 32'h1FEA617A;
            default:  seed = 32'hF8CA4DDC;
        endcase
        return seed;
    endfunction

endpackage

@@ hw/rtl/cartridge_rom_checksum_unit.sv @@
// Top level of the cartridge ROM checksum unit.
//
// Requests arrive on i_valid/i_req and are taken at an edge where i_valid is
// high and o_stall is low. A request either loads one word of the 6105 mixing
// table or checksums one ROM word; the first ROM word after reset or after a
// ROM word marked last seeds the accumulators for the configured variant.
// Only a ROM word marked last yields a result, on o_valid/o_res, taken at an
// edge where o_valid is high and i_stall is low.
// A result shows on o_valid after its last word is taken, through three
// register stages: the input register, the final-value register loaded
// by the accumulator update, and the output register fed by the combination
// and its 6106 multiply. One request is accepted every cycle while o_stall
// is low.
// While the receiver stalls, a result holds; requests keep flowing until the
// final-value stage is also occupied, after which o_stall rises.
// Configuration writes on i_cfg_valid are always taken (o_cfg_ready is high)
// and must only be issued while the unit is idle.
// Synchronous reset clears the handshake state, the run state and the config
// registers; data registers and the table stay undefined until written.
module cartridge_rom_checksum_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  crom_pkg::t_in_req              i_req,
    output logic                           o_valid,
    input  logic                           i_stall,
    output crom_pkg::t_out_res             o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [crom_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crom_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import crom_pkg::*;

    logic       r_in_valid;
    t_in_req    r_in;
    logic       fin_free;
    logic       adv;
    logic       accept;
    logic [1:0] r_variant;
    logic       r_patch;
    t_acc       acc_next;
    logic       fin_load;

    assign adv      = r_in_valid && fin_free;
    assign o_stall  = r_in_valid && !fin_free;
    assign accept   = i_valid && !o_stall;
    assign fin_load = adv && (r_in.action == ACT_CHECK) && r_in.last;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_variant  <= VAR_6102;
            r_patch    <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VARIANT: r_variant <= i_cfg_data[1:0];
                    CFG_PATCH:   r_patch   <= i_cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_req;
        end
    end

    crom_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_req      (r_in),
        .i_variant  (r_variant),
        .i_patch    (r_patch),
        .o_acc_next (acc_next)
    );

    crom_combine u_combine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fin_load),
        .i_acc      (acc_next),
        .i_variant  (r_variant),
        .i_stall    (i_stall),
        .o_fin_free (fin_free),
        .o_valid    (o_valid),
        .o_res      (o_res)
    );

endmodule

@@ hw/rtl/crom_accum.sv @@
// Accumulator update for one ROM word, plus the 6105 mixing table memory.
module crom_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  crom_pkg::t_in_req  i_req,
    input  logic [1:0]         i_variant,
    input  logic               i_patch,
    output crom_pkg::t_acc     o_acc_next
);
    import crom_pkg::*;

    logic [31:0]       mem [TABLE_WORDS];
    logic [31:0]       r_tbl_rd;
    t_acc              r_acc;
    t_acc              n_acc;
    t_acc              base;
    logic [TBL_AW-1:0] r_pos;
    logic [TBL_AW-1:0] n_pos;
    logic              r_run;
    logic              n_run;
    logic              do_check;
    logic              do_write;
    logic [31:0]       d;
    logic [63:0]       rot_wide;
    logic [31:0]       rot;
    logic [32:0]       sum_wide;
    logic [31:0]       tbl_word;

    assign d        = i_req.word;
    assign do_check = i_adv && (i_req.action == ACT_CHECK);
    assign do_write = i_adv && (i_req.action == ACT_TABLE);

    always_comb begin
        if (r_run) begin
            base = r_acc;
        end else begin
            base = '{default: variant_seed(i_variant)};
        end

        rot_wide = {d, d} << d[4:0];
        rot      = rot_wide[63:32];
        sum_wide = {1'b0, base.plain_sum} + {1'b0, d};

        n_acc.plain_sum   = sum_wide[31:0];
        n_acc.carry_count = base.carry_count + {31'd0, sum_wide[32]};
        n_acc.plain_xor   = base.plain_xor ^ d;
        n_acc.rotate_sum  = base.rotate_sum + rot;
        if (base.select_xor > d) begin
            n_acc.select_xor = base.select_xor ^ rot;
        end else begin
            n_acc.select_xor = base.select_xor ^ n_acc.plain_sum ^ d;
        end

        // The patched entry reads as zero; the stored word itself is kept.
        if (i_patch && (r_pos == PATCH_ADDR)) begin
            tbl_word = 32'd0;
        end else begin
            tbl_word = r_tbl_rd;
        end
        if (i_variant == VAR_6105) begin
            n_acc.mix_sum = base.mix_sum + (tbl_word ^ d);
        end else begin
            n_acc.mix_sum = base.mix_sum + (n_acc.rotate_sum ^ d);
        end
    end

    // The position returns to zero when a run closes, so the prefetched table
    // word is always the entry the next word of a run will use.
    always_comb begin
        n_pos = r_pos;
        n_run = r_run;
        if (do_check) begin
            if (i_req.last) begin
                n_pos = '0;
                n_run = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
                n_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_run <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_run <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_check) begin
            r_acc <= n_acc;
        end
    end

    // Table memory: one write port, one registered read of the next position.
    // A write to that same entry is forwarded so the update takes effect at once.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[i_req.table_index] <= d;
        end
        if (do_write && (i_req.table_index == n_pos)) begin
            r_tbl_rd <= d;
        end else begin
            r_tbl_rd <= mem[n_pos];
        end
    end

    assign o_acc_next = n_acc;

endmodule

@@ hw/rtl/crom_combine.sv @@
// Final-value stage and checksum combination into the output register.
module crom_combine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  crom_pkg::t_acc     i_acc,
    input  logic [1:0]         i_variant,
    input  logic               i_stall,
    output logic               o_fin_free,
    output logic               o_valid,
    output crom_pkg::t_out_res o_res
);
    import crom_pkg::*;

    logic     r_fin_valid;
    t_acc     r_fin;
    logic     r_out_valid;
    t_out_res r_out;
    t_out_res n_out;
    logic     out_free;
    logic [31:0] prod_one;
    logic [31:0] prod_two;

    assign out_free   = !r_out_valid || !i_stall;
    assign o_fin_free = !r_fin_valid || out_free;

    always_comb begin
        prod_one = r_fin.plain_sum * r_fin.carry_count;
        prod_two = r_fin.rotate_sum * r_fin.select_xor;
        case (i_variant)
            VAR_6103: begin
                n_out.checksum_one = (r_fin.plain_sum ^ r_fin.carry_count) + r_fin.plain_xor;
                n_out.checksum_two = (r_fin.rotate_sum ^ r_fin.select_xor) + r_fin.mix_sum;
            end
            VAR_6106: begin
                n_out.checksum_one = prod_one + r_fin.plain_xor;
                n_out.checksum_two = prod_two + r_fin.mix_sum;
            end
            default: begin
                n_out.checksum_one = r_fin.plain_sum ^ r_fin.carry_count ^ r_fin.plain_xor;
                n_out.checksum_two = r_fin.rotate_sum ^ r_fin.select_xor ^ r_fin.mix_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_fin_free) begin
                r_fin_valid <= i_load;
            end
            if (out_free) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_free && i_load) begin
            r_fin <= i_acc;
        end
        if (out_free && r_fin_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

@@ hw/rtl/crom_checker.sv @@
// Port-level checks of the checksum unit and the bind that attaches them.
`include "cartridge_rom_checksum_unit_assert.svh"

module crom_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_stall,
    input logic               o_valid,
    input logic               o_stall,
    input crom_pkg::t_out_res o_res
);
    import crom_pkg::*;

    // Reset empties the output stage by the next edge.
    `CROM_ASSERT_NXT_RST(a_rst_clears_out, !i_rst_n, !o_valid)
    // Back-pressure needs both result stages full, so never with the output empty.
    `CROM_ASSERT_IMP(a_stall_needs_result, !o_valid, !o_stall)
    // Requests are only held back when the receiver itself stalls.
    `CROM_ASSERT_IMP(a_stall_from_receiver, o_stall, i_stall)
    `CROM_ASSERT_NXT(a_result_holds, o_valid && i_stall, o_valid && $stable(o_res))

endmodule

bind cartridge_rom_checksum_unit crom_checker u_crom_checker (.*);

@@ verif/tb_cartridge_rom_checksum_unit.sv @@
// Self-checking testbench for the cartridge ROM checksum unit with a scoreboard class.
module tb_cartridge_rom_checksum_unit;
    import crom_pkg::*;

    localparam int ITEM_TARGET   = 1150;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_pattern_e;

    // Predicts the two header checksums for every run and keeps them until they come out.
    class checksum_tracker;
        logic [1:0]        variant;
        logic              patch;
        logic [31:0]       mix_acc, sel_acc, xor_acc, carry_acc, rot_acc, sum_acc;
        logic [31:0]       mix_words [TABLE_WORDS];
        logic [TBL_AW-1:0] position;
        bit                in_run;
        t_out_res          pending_sums [$];
        int                errors, results_seen, requests_seen, table_loads;
        int                runs_by_variant [4];

        function new();
            variant       = VAR_6102;
            patch         = 1'b0;
            in_run        = 1'b0;
            position      = '0;
            errors        = 0;
            results_seen  = 0;
            requests_seen = 0;
            table_loads   = 0;
            {mix_acc, sel_acc, xor_acc, carry_acc, rot_acc, sum_acc} = '0;
            foreach (runs_by_variant[i]) runs_by_variant[i] = 0;
        endfunction

        function logic [31:0] boot_seed(input logic [1:0] v);
            case (v)
                VAR_6103: return 32'hA3886759;
                VAR_6105: return 32'hDF26F436;
                VAR_6106: return 32'h1FEA617A;
                default:  return 32'hF8CA4DDC;
            endcase
        endfunction

        function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_VARIANT: variant = data[1:0];
                CFG_PATCH:   patch   = data[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_sums.size();
        endfunction

        function void absorb_request(input t_in_req rq);
            logic [31:0] d, rot, tword, seed;
            logic [32:0] wide;
            t_out_res    sums;
            requests_seen++;
            if (rq.action == ACT_TABLE) begin
                mix_words[rq.table_index] = rq.word;
                table_loads++;
                return;
            end
            d = rq.word;
            if (!in_run) begin
                seed = boot_seed(variant);
                {mix_acc, sel_acc, xor_acc, carry_acc, rot_acc, sum_acc} = {6{seed}};
                position = '0;
                in_run   = 1'b1;
                runs_by_variant[variant]++;
            end
            rot = (d[4:0] == 5'd0) ? d
                : ((d << d[4:0]) | (d >> (6'd32 - {1'b0, d[4:0]})));
            wide = {1'b0, sum_acc} + {1'b0, d};
            if (wide[32]) carry_acc = carry_acc + 32'd1;
            sum_acc = wide[31:0];
            xor_acc = xor_acc ^ d;
            rot_acc = rot_acc + rot;
            // The select accumulator compares against the word before folding it in.
            if (sel_acc > d) sel_acc = sel_acc ^ rot;
            else sel_acc = sel_acc ^ sum_acc ^ d;
            if (variant == VAR_6105) begin
                tword = (patch && position == PATCH_ADDR) ? 32'd0 : mix_words[position];
                mix_acc = mix_acc + (tword ^ d);
            end else begin
                mix_acc = mix_acc + (rot_acc ^ d);
            end
            position = position + 1'b1;
            if (!rq.last) return;
            case (variant)
                VAR_6103: begin
                    sums.checksum_one = (sum_acc ^ carry_acc) + xor_acc;
                    sums.checksum_two = (rot_acc ^ sel_acc) + mix_acc;
                end
                VAR_6106: begin
                    sums.checksum_one = sum_acc * carry_acc + xor_acc;
                    sums.checksum_two = rot_acc * sel_acc + mix_acc;
                end
                default: begin
                    sums.checksum_one = sum_acc ^ carry_acc ^ xor_acc;
                    sums.checksum_two = rot_acc ^ sel_acc ^ mix_acc;
                end
            endcase
            in_run = 1'b0;
            pending_sums.push_back(sums);
        endfunction

        task report(input string msg);
            if (errors < 40) $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_checksums(input t_out_res got);
            t_out_res want;
            if (pending_sums.size() == 0) begin
                report($sformatf("result %h/%h with no checksum pending",
                                 got.checksum_one, got.checksum_two));
                return;
            end
            want = pending_sums.pop_front();
            results_seen++;
            if (got.checksum_one !== want.checksum_one)
                report($sformatf("checksum_one got %h want %h",
                                 got.checksum_one, want.checksum_one));
            if (got.checksum_two !== want.checksum_two)
                report($sformatf("checksum_two got %h want %h",
                                 got.checksum_two, want.checksum_two));
        endtask

        task close_out();
            if (pending_sums.size() != 0)
                report($sformatf("%0d checksum results never arrived", pending_sums.size()));
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_in_req               i_req       = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_out_res              o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    checksum_tracker tracker;
    int              items_sent = 0;
    int              burst_left = 0;
    bit              gaps_on    = 1'b1;
    int              cycles     = 0;
    stall_pattern_e  stall_mode = STALL_NONE;
    int              stall_span = 0;

    cartridge_rom_checksum_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver backpressure switches between several patterns of random length.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= stall_pattern_e'($urandom_range(0, 3));
            stall_span <= $urandom_range(32, 256);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 7) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= (stall_span % 8 < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tracker != null) begin
            if (i_cfg_valid && o_cfg_ready) tracker.write_register(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) tracker.absorb_request(i_req);
            if (o_valid && !i_stall) tracker.compare_checksums(o_res);
        end
    end

    function automatic t_in_req table_req(input logic [TBL_AW-1:0] idx,
                                          input logic [31:0] w, input logic lst);
        t_in_req rq;
        rq.action      = ACT_TABLE;
        rq.table_index = idx;
        rq.word        = w;
        rq.last        = lst;
        return rq;
    endfunction

    function automatic t_in_req rom_req(input logic [31:0] w, input logic lst);
        t_in_req rq;
        rq.action      = ACT_CHECK;
        rq.table_index = TBL_AW'($urandom_range(0, TABLE_WORDS - 1));
        rq.word        = w;
        rq.last        = lst;
        return rq;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return 32'($urandom_range(0, 63));
            4:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic idle(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sends one request, inserting a random gap when gaps are on whenever a burst runs out.
    task automatic push(input t_in_req rq);
        if (burst_left == 0) begin
            if (gaps_on) idle($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_req   <= rq;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Holds off the sender until every pending checksum is out and the pipeline is empty.
    // It waits for a clock edge first so the last request sent is already in the scoreboard.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] v, input logic p);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_VARIANT;
        i_cfg_data  <= CFG_DATA_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_PATCH;
        i_cfg_data  <= CFG_DATA_W'(p);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int run_len, run_count;
        bit leave_open;
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table loads (one marked last), carries, zero rotates, every variant.
        configure(VAR_6102, 1'b0);
        push(table_req(6'd63, 32'hFFFF_FFFF, 1'b1));
        push(table_req(6'd0, 32'h0000_0000, 1'b0));
        push(table_req(6'd1, 32'h8000_0001, 1'b0));
        push(table_req(6'd2, 32'h1234_5678, 1'b0));
        push(rom_req(32'h0000_0000, 1'b0));
        push(rom_req(32'hFFFF_FFFF, 1'b0));
        push(rom_req(32'h0000_001F, 1'b0));
        push(rom_req(32'h8000_0000, 1'b1));
        settle();
        configure(VAR_6103, 1'b0);
        push(rom_req(32'hFFFF_FFFF, 1'b0));
        push(rom_req(32'hFFFF_FFFF, 1'b1));
        push(rom_req(32'h0000_0001, 1'b1));
        settle();
        configure(VAR_6106, 1'b1);
        push(rom_req(32'hDEAD_BEEF, 1'b0));
        push(rom_req(32'hFFFF_FFFF, 1'b1));
        settle();
        // Only entries 0 to 2 and 63 are loaded so far, so 6105 runs stay within three words.
        configure(VAR_6105, 1'b1);
        push(rom_req(32'hFFFF_FFFF, 1'b0));
        push(rom_req(32'h0000_0000, 1'b0));
        push(rom_req(32'h7FFF_FFFF, 1'b1));
        settle();
        configure(VAR_6105, 1'b0);
        push(rom_req(32'h0000_0020, 1'b0));
        push(rom_req(32'hFFFF_FFE0, 1'b1));
        settle();
        // A run left open across a variant change, with a table load in the middle.
        configure(VAR_6102, 1'b0);
        push(rom_req(32'h1357_9BDF, 1'b0));
        push(rom_req(32'hFFFF_FFFF, 1'b0));
        settle();
        configure(VAR_6106, 1'b1);
        push(table_req(6'd5, $urandom, 1'b0));
        push(rom_req(32'hFFFF_FFFE, 1'b0));
        push(rom_req(32'h2468_ACE0, 1'b1));
        settle();

        // Fill the whole table so any 6105 run may read every entry.
        for (int k = 0; k < TABLE_WORDS; k++)
            push(table_req(TBL_AW'(k), pick_word(), 1'($urandom_range(0, 1))));

        while (items_sent < ITEM_TARGET) begin
            settle();
            configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            gaps_on    = ($urandom_range(0, 3) != 0);
            run_count  = $urandom_range(1, 6);
            leave_open = ($urandom_range(0, 4) == 0);
            for (int r = 0; r < run_count; r++) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140)
                                                      : $urandom_range(1, 12);
                for (int k = 0; k < run_len; k++) begin
                    if ($urandom_range(0, 11) == 0)
                        push(table_req(TBL_AW'($urandom_range(0, TABLE_WORDS - 1)),
                                       pick_word(), 1'($urandom_range(0, 1))));
                    push(rom_req(pick_word(),
                                 (k == run_len - 1) && !(leave_open && r == run_count - 1)));
                end
            end
        end

        settle();
        tracker.close_out();
        $display("Sent %0d requests (%0d table loads) and checked %0d checksum results.",
                 tracker.requests_seen, tracker.table_loads, tracker.results_seen);
        $display("Runs per variant 6102/6103/6105/6106: %0d/%0d/%0d/%0d.",
                 tracker.runs_by_variant[0], tracker.runs_by_variant[1],
                 tracker.runs_by_variant[2], tracker.runs_by_variant[3]);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
